// ===== rtl/bpre_pkg.sv =====
// ---------------------------------------------------------------------------
// bpre_pkg: shared types and constants of the band peak RPM estimator
// Holds the word formats of both channels, the register index codes, the
// register reset values and the command and status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package bpre_pkg;

	localparam int MAG_W = 32;
	localparam int IDX_W = 12;
	localparam int HZ_W = 32;
	localparam int RPM_W = 40;

	// Interpolation offset magnitude is at most one bin in Q16.
	localparam int OFF_W = 17;
	localparam int QUO_W = 18;
	localparam int DIV_STEPS = QUO_W;
	localparam logic [QUO_W-1:0] OFF_MAX = QUO_W'(65536);

	localparam logic [HZ_W-1:0] HZ_PER_BIN_RESET = 32'd65536;
	localparam logic [IDX_W-1:0] BAND_FIRST_RESET = 12'd15;
	localparam logic [IDX_W-1:0] BAND_LAST_RESET = 12'd50;
	localparam logic [HZ_W-1:0] MIN_FREQ_RESET = 32'd983040;

	typedef enum logic [1:0] {
		CFG_HZ_PER_BIN = 2'd0,
		CFG_BAND_FIRST = 2'd1,
		CFG_BAND_LAST  = 2'd2,
		CFG_MIN_FREQ   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [MAG_W-1:0] bin_mag;
		logic             last_bin;
	} bin_word_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm_q8;
		logic [IDX_W-1:0] peak_index;
		logic [MAG_W-1:0] peak_mag;
		logic             rpm_valid;
	} res_word_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic refine;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

// ===== rtl/bpre_div.sv =====
// ---------------------------------------------------------------------------
// bpre_div: restoring divider for the interpolation offset
// Computes round(32768 * |num| / |den|) one quotient bit per cycle. Values
// of four bins or more are flagged as overflow, since the caller saturates
// at one bin anyway.
// ---------------------------------------------------------------------------
module bpre_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [32:0]         num,
	input  logic signed [34:0]         den,
	output logic                       done,
	output logic [bpre_pkg::QUO_W-1:0] quo,
	output logic                       ovf,
	output logic                       neg
);
	import bpre_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [31:0]      an;
	logic [33:0]      ad;
	logic [47:0]      dvd;
	logic [33:0]      rem_q;
	logic [QUO_W-1:0] dvd_q;
	logic [33:0]      ad_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [34:0]      trial;
	logic [34:0]      diff;

	always_comb begin
		an = num[32] ? 32'(-num) : num[31:0];
		ad = den[34] ? 34'(-den) : den[33:0];
		// Adding half the divisor rounds to nearest.
		dvd = {1'b0, an, 15'b0} + 48'(ad[33:1]);
		trial = {rem_q, dvd_q[QUO_W-1]};
		diff = trial - {1'b0, ad_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 34'(dvd[47:QUO_W]);
			dvd_q <= dvd[QUO_W-1:0];
			ad_q <= ad;
			quo_q <= '0;
			ovf_q <= 34'(dvd[47:QUO_W]) >= ad;
			neg_q <= num[32] != den[34];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			if (!diff[34]) begin
				rem_q <= diff[33:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign ovf = ovf_q;
	assign neg = neg_q;

endmodule

// ===== rtl/bpre_dp.sv =====
// ---------------------------------------------------------------------------
// bpre_dp: datapath of the band peak RPM estimator
// Holds the registers, scans the bins for the in-band peak and its
// neighbours, then refines the peak, scales it and forms the RPM word.
// ---------------------------------------------------------------------------
module bpre_dp #(
	parameter int MAX_HALF_BINS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpre_pkg::cmd_t         cmd,
	output bpre_pkg::stat_t        stat,
	input  bpre_pkg::bin_word_t    bin_word,
	input  logic                   cfg_we,
	input  bpre_pkg::cfg_index_t   cfg_index,
	input  logic [31:0]            cfg_data,
	output bpre_pkg::res_word_t    res_word
);
	import bpre_pkg::*;

	localparam int CNT_W = $clog2(MAX_HALF_BINS);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_HALF_BINS - 1);

	// Configuration registers.
	logic [HZ_W-1:0]  hz_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic [HZ_W-1:0]  minf_q;

	// Scan state.
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] prev_q;
	logic [MAG_W-1:0] best_q;
	logic [IDX_W-1:0] idx_q;
	logic [MAG_W-1:0] left_q;
	logic [MAG_W-1:0] right_q;
	logic             rpend_q;
	logic             rseen_q;

	logic [MAG_W-1:0] best_n;
	logic [IDX_W-1:0] idx_n;
	logic [MAG_W-1:0] left_n;
	logic [MAG_W-1:0] right_n;
	logic             rpend_n;
	logic             rseen_n;

	logic [IDX_W-1:0] eff_first;
	logic [CMP_W-1:0] i_ext;
	logic [CMP_W-1:0] first_ext;
	logic [CMP_W-1:0] last_ext;
	logic             hit;
	logic [MAG_W-1:0] mag;

	// Operands of the end-of-spectrum computation.
	logic [MAG_W-1:0] opl_q;
	logic [MAG_W-1:0] opc_q;
	logic [MAG_W-1:0] opr_q;
	logic             oprs_q;
	logic [IDX_W-1:0] opidx_q;

	logic signed [32:0] num;
	logic signed [34:0] den;
	logic               skip;
	logic               div_done;
	logic [QUO_W-1:0]   quo;
	logic               div_ovf;
	logic               div_neg;
	logic               off_sat;
	logic [OFF_W-1:0]   off_mag;
	logic signed [29:0] off;
	logic signed [29:0] base;
	logic signed [29:0] ref_s;

	logic [28:0]  refined_q;
	logic [44:0]  lo_q;
	logic [44:0]  hi_q;
	logic [60:0]  prod_q;
	logic         freq_ok;
	logic [66:0]  x60;
	logic [42:0]  rnd;
	logic [RPM_W-1:0] rpm;
	res_word_t    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_q <= HZ_PER_BIN_RESET;
			first_q <= BAND_FIRST_RESET;
			last_q <= BAND_LAST_RESET;
			minf_q <= MIN_FREQ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HZ_PER_BIN: hz_q <= cfg_data;
				CFG_BAND_FIRST: first_q <= cfg_data[IDX_W-1:0];
				CFG_BAND_LAST:  last_q <= cfg_data[IDX_W-1:0];
				CFG_MIN_FREQ:   minf_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mag = bin_word.bin_mag;
		// Bin 0 holds DC and is never searched.
		eff_first = (first_q == '0) ? IDX_W'(1) : first_q;
		i_ext = CMP_W'(cnt_q);
		first_ext = CMP_W'(eff_first);
		last_ext = CMP_W'(last_q);
		hit = (i_ext >= first_ext) && (i_ext <= last_ext) &&
			((i_ext == first_ext) || (mag > best_q));

		best_n = best_q;
		idx_n = idx_q;
		left_n = left_q;
		right_n = right_q;
		rpend_n = rpend_q;
		rseen_n = rseen_q;
		if (rpend_q) begin
			right_n = mag;
			rseen_n = 1'b1;
			rpend_n = 1'b0;
		end
		if (hit) begin
			best_n = mag;
			idx_n = i_ext[IDX_W-1:0];
			left_n = prev_q;
			right_n = '0;
			rpend_n = 1'b1;
			rseen_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			prev_q <= '0;
			best_q <= '0;
			idx_q <= BAND_FIRST_RESET;
			left_q <= '0;
			right_q <= '0;
			rpend_q <= 1'b0;
			rseen_q <= 1'b0;
		end else if (cmd.take) begin
			if (bin_word.last_bin) begin
				cnt_q <= '0;
				prev_q <= '0;
				best_q <= '0;
				idx_q <= eff_first;
				left_q <= '0;
				right_q <= '0;
				rpend_q <= 1'b0;
				rseen_q <= 1'b0;
			end else begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
				prev_q <= mag;
				best_q <= best_n;
				idx_q <= idx_n;
				left_q <= left_n;
				right_q <= right_n;
				rpend_q <= rpend_n;
				rseen_q <= rseen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && bin_word.last_bin) begin
			opl_q <= left_n;
			opc_q <= best_n;
			opr_q <= right_n;
			oprs_q <= rseen_n;
			opidx_q <= idx_n;
		end
	end

	always_comb begin
		num = $signed({1'b0, opl_q}) - $signed({1'b0, opr_q});
		den = $signed({3'b0, opl_q}) + $signed({3'b0, opr_q}) -
			$signed({2'b0, opc_q, 1'b0});
		skip = !oprs_q || (den == '0);
	end

	bpre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo),
		.ovf    (div_ovf),
		.neg    (div_neg)
	);

	assign stat.div_done = div_done;

	always_comb begin
		// A centre that is not the local maximum can push the offset past one bin.
		off_sat = div_ovf || (quo > OFF_MAX);
		off_mag = off_sat ? OFF_MAX[OFF_W-1:0] : quo[OFF_W-1:0];
		if (skip) begin
			off = '0;
		end else if (div_neg) begin
			off = -$signed({13'b0, off_mag});
		end else begin
			off = $signed({13'b0, off_mag});
		end
		base = $signed({2'b0, opidx_q, 16'b0});
		ref_s = base + off;
	end

	always_comb begin
		freq_ok = prod_q >= {13'b0, minf_q, 16'b0};
		// Times 60 is times 64 minus times 4, then round Q32 Hz to Q8.
		x60 = {prod_q, 6'b0} - {4'b0, prod_q, 2'b0} + 67'h800000;
		rnd = x60[66:24];
		rpm = (rnd[42:RPM_W] != '0) ? '1 : rnd[RPM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.refine) begin
			refined_q <= ref_s[29] ? '0 : ref_s[28:0];
		end
		if (cmd.mul_lo) begin
			lo_q <= 45'(refined_q) * 45'(hz_q[15:0]);
		end
		if (cmd.mul_hi) begin
			hi_q <= 45'(refined_q) * 45'(hz_q[31:16]);
		end
		if (cmd.sum) begin
			prod_q <= 61'(lo_q) + {hi_q, 16'b0};
		end
		if (cmd.fin) begin
			res_q.rpm_q8 <= freq_ok ? rpm : '0;
			res_q.peak_index <= opidx_q;
			res_q.peak_mag <= opc_q;
			res_q.rpm_valid <= freq_ok;
		end
	end

	assign res_word = res_q;

endmodule

// ===== rtl/bpre_ctrl.sv =====
// ---------------------------------------------------------------------------
// bpre_ctrl: controller of the band peak RPM estimator
// Takes bins while scanning, then sequences division, refinement, the two
// partial products and the RPM stage, and owns the result valid flag.
// ---------------------------------------------------------------------------
module bpre_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            bin_valid,
	input  logic            last_bin,
	output logic            bin_stall,
	output logic            res_valid,
	input  logic            res_stall,
	input  bpre_pkg::stat_t stat,
	output bpre_pkg::cmd_t  cmd
);
	import bpre_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DIV_LD  = 7'b0000010,
		ST_DIV_RUN = 7'b0000100,
		ST_MUL_LO  = 7'b0001000,
		ST_MUL_HI  = 7'b0010000,
		ST_SUM     = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   res_valid_q;
	logic   take;
	logic   load;

	assign take = bin_valid && (state_q == ST_IDLE);
	// The result register frees up in the same cycle its word is taken.
	assign load = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:    if (take && last_bin) state_n = ST_DIV_LD;
			ST_DIV_LD:  state_n = ST_DIV_RUN;
			ST_DIV_RUN: if (stat.div_done) state_n = ST_MUL_LO;
			ST_MUL_LO:  state_n = ST_MUL_HI;
			ST_MUL_HI:  state_n = ST_SUM;
			ST_SUM:     state_n = ST_FIN;
			ST_FIN:     if (load) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd.take = take;
		cmd.div_start = state_q == ST_DIV_LD;
		cmd.refine = (state_q == ST_DIV_RUN) && stat.div_done;
		cmd.mul_lo = state_q == ST_MUL_LO;
		cmd.mul_hi = state_q == ST_MUL_HI;
		cmd.sum = state_q == ST_SUM;
		cmd.fin = load;
	end

	assign bin_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;

endmodule

// ===== rtl/band_peak_rpm_estimator.sv =====
// ---------------------------------------------------------------------------
// band_peak_rpm_estimator: in-band spectral peak with parabolic refinement
// Finds the strongest bin of a half spectrum within the configured band,
// refines its position from its neighbours, scales it to Hz and gives RPM.
//
//   channel  handshake             word
//   bins     bin_valid/bin_stall   bin_word: bin_mag, last_bin
//   result   res_valid/res_stall   res_word: rpm_q8, peak_index, peak_mag,
//                                            rpm_valid
//   config   cfg_we                cfg_index, cfg_data
//
// One bin is taken per cycle while bin_stall is low. After the last bin,
// bin_stall stays high through the load and the bit-serial offset divider
// with the refinement, two 29x16 partial products, the sum and the RPM
// stage, and longer while an earlier result waits in the output register.
// Reset loads the register defaults and clears the scan and result valid.
// A held result does not block the next spectrum's bins.
// ---------------------------------------------------------------------------
module band_peak_rpm_estimator #(
	parameter int MAX_HALF_BINS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_stall,
	input  bpre_pkg::bin_word_t  bin_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output bpre_pkg::res_word_t  res_word,
	input  logic                 cfg_we,
	input  bpre_pkg::cfg_index_t cfg_index,
	input  logic [31:0]          cfg_data
);
	import bpre_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bpre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.last_bin  (bin_word.last_bin),
		.bin_stall (bin_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpre_dp #(
		.MAX_HALF_BINS (MAX_HALF_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.bin_word  (bin_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_word  (res_word)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for band_peak_rpm_estimator
// Streams half spectra into the estimator and checks every result word
// against a cycle-free predictor of the in-band peak search, the parabolic
// refinement and the RPM scaling. Directed spectra cover ties, offset
// clamping, flat and empty bands, DC exclusion and the frequency floor;
// random spectra run under several register settings while both channels
// idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
	import bpre_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [63:0] RPM_SAT = 64'hFF_FFFF_FFFF;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       bin_valid = 1'b0;
	logic       bin_stall;
	bin_word_t  bin_word = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_word_t  res_word;
	logic       cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_HZ_PER_BIN;
	logic [31:0] cfg_data = '0;

	band_peak_rpm_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_word  (bin_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register mirror.
	logic [31:0] hz_per_bin_r = HZ_PER_BIN_RESET;
	logic [11:0] band_first_r = BAND_FIRST_RESET;
	logic [11:0] band_last_r = BAND_LAST_RESET;
	logic [31:0] min_freq_r = MIN_FREQ_RESET;

	// Scan state of the spectrum in progress.
	logic [11:0] bin_count = '0;
	logic [31:0] prev_bin_mag = '0;
	logic [31:0] best_mag = '0;
	logic [11:0] best_bin = BAND_FIRST_RESET;
	logic [31:0] left_mag = '0;
	logic [31:0] right_mag = '0;
	logic        right_due = 1'b0;
	logic        right_have = 1'b0;

	res_word_t expected_rpm[$];
	res_word_t rpm_want;
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	bit        sender_gaps = 1'b1;
	int        hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Refine the peak and scale it to RPM from the current scan state.
	function automatic res_word_t estimate_rpm();
		longint      l, c, r, den, num, off, refined;
		logic [63:0] an, ad, quo, prod, whole, frac, rpm;
		logic        reached;
		res_word_t   w;
		l = longint'({32'b0, left_mag});
		c = longint'({32'b0, best_mag});
		r = longint'({32'b0, right_mag});
		den = l - 2 * c + r;
		num = l - r;
		off = 0;
		if (right_have && den != 0) begin
			an = (num < 0) ? -num : num;
			ad = (den < 0) ? -den : den;
			quo = (an * 64'd32768 + ad / 64'd2) / ad;
			// A centre that is not the local maximum pulls by at most one bin.
			if (quo > 64'd65536)
				quo = 64'd65536;
			off = ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
		end
		refined = longint'({52'b0, best_bin}) * 65536 + off;
		if (refined < 0)
			refined = 0;
		prod = refined * {32'b0, hz_per_bin_r};
		reached = prod >= ({32'b0, min_freq_r} << 16);
		rpm = '0;
		if (reached) begin
			whole = prod >> 24;
			frac = prod & 64'hFF_FFFF;
			rpm = whole * 64'd60 + ((frac * 64'd60 + 64'h80_0000) >> 24);
			if (rpm > RPM_SAT)
				rpm = RPM_SAT;
		end
		w.rpm_q8 = rpm[39:0];
		w.peak_index = best_bin;
		w.peak_mag = best_mag;
		w.rpm_valid = reached;
		return w;
	endfunction

	// Advance the scan by one accepted bin word.
	task automatic scan_bin(input logic [31:0] mag, input logic last);
		logic [11:0] first;
		first = (band_first_r == 12'd0) ? 12'd1 : band_first_r;
		if (right_due) begin
			right_mag = mag;
			right_have = 1'b1;
			right_due = 1'b0;
		end
		if (bin_count >= first && bin_count <= band_last_r &&
				(bin_count == first || mag > best_mag)) begin
			best_mag = mag;
			best_bin = bin_count;
			left_mag = prev_bin_mag;
			right_due = 1'b1;
			right_have = 1'b0;
			right_mag = '0;
		end
		prev_bin_mag = mag;
		if (!last) begin
			bin_count = bin_count + 12'd1;
		end else begin
			expected_rpm.push_back(estimate_rpm());
			bin_count = '0;
			prev_bin_mag = '0;
			best_mag = '0;
			best_bin = first;
			left_mag = '0;
			right_mag = '0;
			right_due = 1'b0;
			right_have = 1'b0;
		end
	endtask

	task automatic send_bin(input logic [31:0] mag, input logic last);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (sender_gaps && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			bin_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		bin_valid <= 1'b1;
		bin_word <= {mag, last};
		do @(posedge clk); while (bin_stall);
		scan_bin(mag, last);
	endtask

	task automatic send_spectrum(input logic [31:0] mags[$]);
		foreach (mags[k])
			send_bin(mags[k], k == mags.size() - 1);
	endtask

	// Wait until every result is in and the block has settled.
	task automatic drain();
		@(negedge clk);
		bin_valid <= 1'b0;
		while (expected_rpm.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; configure lowers it after the last write.
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_HZ_PER_BIN: hz_per_bin_r = value;
			CFG_BAND_FIRST: band_first_r = value[11:0];
			CFG_BAND_LAST:  band_last_r = value[11:0];
			CFG_MIN_FREQ:   min_freq_r = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] hz, input logic [11:0] first,
			input logic [11:0] last, input logic [31:0] floor_hz);
		drain();
		write_reg(CFG_HZ_PER_BIN, hz);
		write_reg(CFG_BAND_FIRST, {20'b0, first});
		write_reg(CFG_BAND_LAST, {20'b0, last});
		write_reg(CFG_MIN_FREQ, floor_hz);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_mag(input int style, input int pos, input int peak);
		logic [31:0] m;
		case (style)
			0: m = $urandom;
			1: m = $urandom_range(0, 3);
			2: begin
				if (pos == peak)
					m = $urandom | 32'h8000_0000;
				else if (pos == peak - 1 || pos == peak + 1)
					m = $urandom >> 1;
				else
					m = $urandom_range(0, 255);
			end
			3: m = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: m = $urandom | 32'hFFFF_0000;
		endcase
		return m;
	endfunction

	// Reset defaults, a spectrum that ends before the band starts.
	task automatic test_band_not_reached();
		send_spectrum('{32'h1234});
	endtask

	task automatic test_ties_and_offsets();
		configure(32'd65536, 12'd2, 12'd5, 32'd0);
		// Equal peaks: the earlier bin stays.
		send_spectrum('{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		// Left neighbour above the centre clamps the offset upward.
		send_spectrum('{32'd0, 32'd10, 32'd5, 32'd1});
		configure(32'd65536, 12'd2, 12'd2, 32'd0);
		// Right neighbour outside the band and above the centre clamps downward.
		send_spectrum('{32'd0, 32'd1, 32'd5, 32'd10});
		// Flat spectrum gives a zero denominator.
		send_spectrum('{32'd7, 32'd7, 32'd7, 32'd7});
		// Peak on the final bin has no right neighbour.
		send_spectrum('{32'd1, 32'd2, 32'd3});
	endtask

	task automatic test_band_edges();
		configure(32'd65536, 12'd10, 12'd5, 32'd0);
		// The empty band keeps the default index loaded at the end of the last spectrum.
		send_spectrum('{32'd1});
		send_spectrum('{32'd3});
		configure(32'd65536, 12'd0, 12'd3, 32'd0);
		// A first bin of zero still keeps DC out of the search.
		send_spectrum('{32'd100, 32'd3, 32'd4});
		configure(32'd1, 12'd1, 12'd4, 32'hFFFF_FFFF);
		send_spectrum('{32'd0, 32'd5, 32'd9});
	endtask

	// The receiver holds off while the sender keeps going, so the input stalls.
	task automatic test_backpressure();
		logic [31:0] mags[$];
		configure(32'd65536, 12'd2, 12'd6, 32'd0);
		hold_req = HOLD_OFF_CYCLES;
		sender_gaps = 1'b0;
		repeat (5) begin
			mags.delete();
			for (int k = 0; k < 8; k++)
				mags.push_back($urandom);
			send_spectrum(mags);
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_spectra();
		int          items, phase, len, hi, peak, style;
		logic [31:0] hz, floor_hz;
		logic [11:0] fb, lb;
		items = 0;
		phase = 0;
		while (items < 480) begin
			case (phase)
				0: begin hz = 32'd1; fb = 12'd0; lb = 12'd4095; floor_hz = 32'd0; end
				1: begin hz = '1; fb = 12'd1; lb = 12'd12; floor_hz = '1; end
				2: begin hz = 32'd65536; fb = 12'd4095; lb = 12'd4095; floor_hz = 32'd0; end
				default: begin
					case ($urandom_range(0, 3))
						0: hz = 32'd1;
						1: hz = '1;
						2: hz = 32'd65536;
						default: hz = $urandom;
					endcase
					if ($urandom_range(0, 3) == 0)
						fb = 12'($urandom_range(0, 1));
					else
						fb = 12'($urandom_range(2, 30));
					case ($urandom_range(0, 5))
						0: lb = fb - 12'd1;
						1: lb = 12'd4095;
						default: lb = fb + 12'($urandom_range(0, 30));
					endcase
					case ($urandom_range(0, 3))
						0: floor_hz = 32'd0;
						1: floor_hz = '1;
						2: floor_hz = $urandom_range(0, 32'h0040_0000);
						default: floor_hz = $urandom;
					endcase
				end
			endcase
			configure(hz, fb, lb, floor_hz);
			repeat ($urandom_range(4, 8)) begin
				hi = ((lb < 12'd60) ? int'(lb) : 60) + 3;
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, hi);
				else
					len = $urandom_range(hi - hi / 3, hi);
				peak = $urandom_range(0, len - 1);
				style = $urandom_range(0, 4);
				for (int k = 0; k < len; k++)
					send_bin(pick_mag(style, k, peak), k == len - 1);
				items += len;
			end
			phase++;
		end
	endtask

	// Receiver: stall patterns that change at random intervals, plus hold-offs.
	initial begin
		int hold_left, mode, mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= 1'($urandom_range(0, 1));
					2: res_stall <= ($urandom_range(0, 7) != 0);
					default: res_stall <= (mode_left % 16) < 11;
				endcase
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_rpm.size() == 0) begin
				note_mismatch("unexpected result word", 64'(res_word.rpm_q8), 64'd0);
			end else begin
				rpm_want = expected_rpm.pop_front();
				if (res_word.rpm_q8 !== rpm_want.rpm_q8)
					note_mismatch("rpm_q8", 64'(res_word.rpm_q8), 64'(rpm_want.rpm_q8));
				if (res_word.peak_index !== rpm_want.peak_index)
					note_mismatch("peak_index", 64'(res_word.peak_index),
						64'(rpm_want.peak_index));
				if (res_word.peak_mag !== rpm_want.peak_mag)
					note_mismatch("peak_mag", 64'(res_word.peak_mag), 64'(rpm_want.peak_mag));
				if (res_word.rpm_valid !== rpm_want.rpm_valid)
					note_mismatch("rpm_valid", 64'(res_word.rpm_valid),
						64'(rpm_want.rpm_valid));
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((bin_valid && !bin_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_band_not_reached();
		test_ties_and_offsets();
		test_band_edges();
		test_backpressure();
		test_random_spectra();
		drain();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
